@@ hw/rtl/mrb_pkg.sv @@
// ----------------------------------------------------------------------------
// mrb_pkg: shared types and constants
// Request kinds, status codes, sequencer states and payload structs.
// ----------------------------------------------------------------------------
package mrb_pkg;

    localparam int CHANNELS    = 8;
    localparam int MEM_BYTES   = 1024;
    localparam int BURST_BYTES = 8;
    localparam int CH_W        = 3;
    localparam int ADDR_W      = 10;
    localparam int SIZE_W      = 11;

    typedef enum logic [2:0] {
        K_OPEN   = 3'd0,
        K_CLOSE  = 3'd1,
        K_WRITE  = 3'd2,
        K_READ   = 3'd3,
        K_PEEK   = 3'd4,
        K_REMOVE = 3'd5,
        K_QUERY  = 3'd6,
        K_RESET  = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADPARAM = 3'd1,
        ST_NOTOPEN  = 3'd2,
        ST_NOFREE   = 3'd3,
        ST_NOROOM   = 3'd4,
        ST_NODATA   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_BYTE,
        S_WAIT,
        S_DONE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  channel;
        logic [9:0]  region_base;
        logic [10:0] count;
        logic [63:0] data;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  channel_out;
        logic [63:0] data_out;
        logic [9:0]  used_length;
        logic        is_empty;
        logic        is_full;
    } t_rsp;

    // memory port command from sequencer to byte store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_cmd;

endpackage

@@ hw/rtl/mrb_if.sv @@
// ----------------------------------------------------------------------------
// mrb_if: request and response channels
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface mrb_req_if import mrb_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mrb_rsp_if import mrb_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/multichannel_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// multichannel_ring_buffer: byte ring buffers in one shared memory
// Top level joining the request sequencer and the byte store.
// ----------------------------------------------------------------------------
// Up to eight channels share one 1024-byte store; each channel owns a
// wrapping region and keeps one slot empty. A request takes one beat in and
// gives exactly one response beat. The block serves one request at a time.
// Open, close, remove, query and reset pass through the check, done and
// output states only; write, read and peek also step the single byte port
// of the store, one byte per cycle, and read and peek then wait for its
// registered read data. The response stays until taken; the next request
// is accepted the cycle after.
module multichannel_ring_buffer import mrb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrb_req_if.sink   req,
    mrb_rsp_if.source rsp
);
    t_mem_cmd   cmd;
    logic [7:0] rdata;

    // sequencer: table, checks and byte stepping
    mrb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req     (req),
        .rsp     (rsp),
        .o_cmd   (cmd),
        .i_rdata (rdata)
    );

    // shared byte store
    mrb_store u_store (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .o_rdata (rdata)
    );
endmodule

@@ hw/rtl/mrb_store.sv @@
// ----------------------------------------------------------------------------
// mrb_store: shared byte memory
// One port, one byte per cycle, registered read data.
// ----------------------------------------------------------------------------
module mrb_store import mrb_pkg::*; (
    input  logic     i_clk,
    input  t_mem_cmd i_cmd,
    output logic [7:0] o_rdata
);
    logic [7:0] r_mem [MEM_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.addr] <= i_cmd.wdata;
        end
        o_rdata <= r_mem[i_cmd.addr];
    end
endmodule

@@ hw/rtl/mrb_seq.sv @@
// ----------------------------------------------------------------------------
// mrb_seq: request sequencer
// Checks a request against the channel table, then, for write, read and peek, steps the byte port.
// ----------------------------------------------------------------------------
module mrb_seq import mrb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mrb_req_if.sink  req,
    mrb_rsp_if.source rsp,
    output t_mem_cmd o_cmd,
    input  logic [7:0] i_rdata
);
    t_state r_state, n_state;
    t_req   r_req;
    t_rsp   r_rsp, n_rsp;
    logic [CHANNELS-1:0] r_open, n_open;
    logic [ADDR_W-1:0] r_base [CHANNELS];
    logic [SIZE_W-1:0] r_size [CHANNELS];
    logic [ADDR_W-1:0] r_rp   [CHANNELS];
    logic [ADDR_W-1:0] r_wp   [CHANNELS];
    logic [ADDR_W-1:0] r_pos, n_pos;   // running position in channel
    logic [3:0]        r_idx, n_idx;   // byte counter
    logic [63:0]       r_dout, n_dout;
    logic [2:0]        r_ch, n_ch;
    logic [2:0]        r_st, n_st;
    logic              n_wr_tbl;
    logic [ADDR_W-1:0] n_new_rp, n_new_wp;

    // values for the selected channel
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] rp, wp, used, nxt;
    logic [SIZE_W:0]   rp_rm;
    logic [SIZE_W-1:0] room;
    logic [CH_W-1:0]   free_ch;
    logic              any_free;

    assign sz = r_size[r_ch];
    assign rp = r_rp[r_ch];
    assign wp = r_wp[r_ch];

    always_comb begin
        logic [SIZE_W-1:0] u;
        if (wp >= rp) u = SIZE_W'(wp) - SIZE_W'(rp);
        else          u = sz + SIZE_W'(wp) - SIZE_W'(rp);
        used = u[ADDR_W-1:0];
        room = (sz == '0) ? '0 : sz - SIZE_W'(1) - u;
    end

    // next position, wrapped within size
    function automatic logic [ADDR_W-1:0] inc_pos(logic [ADDR_W-1:0] p,
                                                  logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] q;
        q = SIZE_W'(p) + SIZE_W'(1);
        if (q >= s) q = '0;
        return q[ADDR_W-1:0];
    endfunction
    assign nxt = inc_pos(r_pos, sz);

    // remove: rp + cnt with cnt <= used < size, one subtract suffices
    always_comb begin
        rp_rm = (SIZE_W+1)'(rp) + (SIZE_W+1)'(r_req.count);
        if (rp_rm >= (SIZE_W+1)'(sz)) rp_rm = rp_rm - (SIZE_W+1)'(sz);
    end

    always_comb begin
        free_ch  = '0;
        any_free = 1'b0;
        for (int i = CHANNELS-1; i >= 0; i--) begin
            if (!r_open[i]) begin
                free_ch  = CH_W'(i);
                any_free = 1'b1;
            end
        end
    end

    assign req.ready = (r_state == S_IDLE);
    assign rsp.valid = (r_state == S_OUT);
    assign rsp.payload = r_rsp;

    always_comb begin
        n_state  = r_state;
        n_rsp    = r_rsp;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_dout   = r_dout;
        n_ch     = r_ch;
        n_st     = r_st;
        n_open   = r_open;
        n_wr_tbl = 1'b0;
        n_new_rp = rp;
        n_new_wp = wp;
        o_cmd.we    = 1'b0;
        o_cmd.addr  = ADDR_W'(SIZE_W'(r_base[r_ch]) + SIZE_W'(r_pos));
        o_cmd.wdata = r_req.data[r_idx[2:0]*8 +: 8];
        case (r_state)
            S_IDLE: begin
                if (req.valid) begin
                    n_ch    = req.payload.channel;
                    n_dout  = '0;
                    n_idx   = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_st    = ST_OK;
                n_state = S_DONE;
                n_pos   = (r_req.kind == K_WRITE) ? wp : rp;
                case (r_req.kind)
                    K_OPEN: begin
                        if (r_req.count == '0 || r_req.count > SIZE_W'(MEM_BYTES))
                            n_st = ST_BADPARAM;
                        else if (!any_free) n_st = ST_NOFREE;
                        else begin
                            n_ch = free_ch;
                            n_open[free_ch] = 1'b1;
                            n_wr_tbl = 1'b1;
                            n_new_rp = '0;
                            n_new_wp = '0;
                        end
                    end
                    K_CLOSE: begin
                        n_open[r_ch] = 1'b0;
                        n_wr_tbl = 1'b1;
                        n_new_rp = '0;
                        n_new_wp = '0;
                    end
                    default: begin
                        if ((r_req.kind inside {K_WRITE, K_READ, K_PEEK}) &&
                            (r_req.count == '0 || r_req.count > SIZE_W'(BURST_BYTES)))
                            n_st = ST_BADPARAM;
                        else if (r_req.kind == K_REMOVE && r_req.count == '0)
                            n_st = ST_BADPARAM;
                        else if (!r_open[r_ch]) n_st = ST_NOTOPEN;
                        else if (r_req.kind == K_WRITE) begin
                            if (r_req.count > room) n_st = ST_NOROOM;
                            else n_state = S_BYTE;
                        end else if (r_req.kind inside {K_READ, K_PEEK}) begin
                            if (r_req.count > SIZE_W'(used)) n_st = ST_NODATA;
                            else n_state = S_BYTE;
                        end else if (r_req.kind == K_REMOVE) begin
                            if (r_req.count > SIZE_W'(used)) n_st = ST_NODATA;
                            else begin
                                n_wr_tbl = 1'b1;
                                n_new_rp = rp_rm[ADDR_W-1:0];
                            end
                        end else if (r_req.kind == K_RESET) begin
                            n_wr_tbl = 1'b1;
                            n_new_rp = '0;
                            n_new_wp = '0;
                        end
                    end
                endcase
            end
            S_BYTE: begin
                // one byte access per cycle
                o_cmd.we = (r_req.kind == K_WRITE);
                n_pos    = nxt;
                n_idx    = r_idx + 4'd1;
                if (r_req.kind != K_WRITE && r_idx != '0)
                    n_dout[(r_idx[2:0]-3'd1)*8 +: 8] = i_rdata;
                if (r_idx == 4'(r_req.count) - 4'd1) begin
                    n_state = (r_req.kind == K_WRITE) ? S_DONE : S_WAIT;
                    if (r_req.kind == K_WRITE) begin
                        n_wr_tbl = 1'b1;
                        n_new_wp = nxt;
                    end
                end
            end
            S_WAIT: begin
                n_dout[(r_idx[2:0]-3'd1)*8 +: 8] = i_rdata;
                if (r_idx == 4'd8) n_dout[63:56] = i_rdata;
                if (r_req.kind == K_READ) begin
                    n_wr_tbl = 1'b1;
                    n_new_rp = r_pos;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // table already updated; build the response
                n_rsp.status      = r_st;
                n_rsp.channel_out = r_ch;
                n_rsp.data_out    = r_dout;
                n_rsp.used_length = r_open[r_ch] ? used : '0;
                n_rsp.is_empty    = r_open[r_ch] && (used == '0);
                n_rsp.is_full     = r_open[r_ch] && (inc_pos(wp, sz) == rp);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_open  <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_base[i] <= '0;
                r_size[i] <= '0;
                r_rp[i]   <= '0;
                r_wp[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            if (r_state == S_CHECK && r_req.kind == K_OPEN && n_wr_tbl) begin
                r_base[n_ch] <= r_req.region_base;
                r_size[n_ch] <= r_req.count;
            end else if (r_state == S_CHECK && r_req.kind == K_CLOSE) begin
                r_base[r_ch] <= '0;
                r_size[r_ch] <= '0;
            end
            if (n_wr_tbl) begin
                r_rp[n_ch] <= n_new_rp;
                r_wp[n_ch] <= n_new_wp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && req.valid) r_req <= req.payload;
        r_rsp  <= n_rsp;
        r_pos  <= n_pos;
        r_idx  <= n_idx;
        r_dout <= n_dout;
        r_ch   <= n_ch;
        r_st   <= n_st;
    end
endmodule

@@ hw/rtl/mrb_checker.sv @@
// ----------------------------------------------------------------------------
// mrb_checker: port checks
// Response ordering and field consistency seen at the ports.
// ----------------------------------------------------------------------------
module mrb_checker import mrb_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input t_rsp rsp_payload
);
    a_no_ready_while_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready) else $error("request taken while response held");
    a_rsp_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_valid && req_ready) |=> !rsp_valid) else $error("response too early");
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp_valid && rsp_payload.is_empty) |-> rsp_payload.used_length == '0)
        else $error("empty with nonzero length");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> rsp_payload.status <= ST_NODATA) else $error("bad status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_payload))
        else $error("response dropped");
endmodule

bind multichannel_ring_buffer mrb_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
